### rtl/core/aarm_pkg.sv
// Package: shared types and constants for the axis-angle rotation matrix pipeline.
`timescale 1ns / 1ps
package aarm_pkg;

    localparam int CORDIC_STAGES_DEF = 14;
    localparam int ATAN_ENTRIES      = 24;
    localparam int CW                = 34;
    localparam int QW                = 26;
    localparam int SQRT_STEPS        = 32;
    localparam int DIV_STEPS         = 26;
    localparam int NORM_LAT          = 2 + SQRT_STEPS + DIV_STEPS + 1;
    localparam int MAT_LAT           = 3;
    localparam int LAT_TOTAL         = NORM_LAT + MAT_LAT;

    localparam logic signed [18:0]   TURN_PER_RAD_Q20 = 19'sd166886;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30  = CW'(32'h26DD3B6A);
    localparam logic [QW-1:0]        ONE_Q24          = QW'(1 << 24);
    localparam logic signed [15:0]   Q14_ONE          = 16'sd16384;

    localparam logic [31:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic               zero_axis;
    } out_t;

    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } unit_t;

    typedef struct packed {
        logic signed [QW-1:0] c;
        logic signed [QW-1:0] s;
    } trig_t;

endpackage

### rtl/core/axis_angle_rotation_matrix_top.sv
// Top level: axis-angle to 3x3 rotation matrix, fully pipelined with a valid/ready stream on each side.
// Takes one request per clock and gives one matrix per request, in order (the square root,
// one result bit a stage over 32 stages, and the 26-stage divider make up most of the
// pipeline; the CORDIC runs alongside and is delayed to match). The whole pipeline advances
// together and halts while a finished matrix waits at the output, so nothing is dropped.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_top import aarm_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int CS_DELAY = NORM_LAT - (CORDIC_STAGES + 2);

    logic                 ce;
    logic [LAT_TOTAL-1:0] vld_reg;
    logic [LAT_TOTAL-1:0] zero_reg;
    logic                 zero_in;
    trig_t                trig;
    trig_t                trig_dly_reg [0:CS_DELAY-1];
    unit_t                unit;

    assign ce      = !vld_reg[LAT_TOTAL-1] || m_ready;
    assign s_ready = ce && aresetn;
    assign m_valid = vld_reg[LAT_TOTAL-1];
    assign zero_in = (s_data.axis_x == '0) && (s_data.axis_y == '0) && (s_data.axis_z == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT_TOTAL-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            zero_reg <= {zero_reg[LAT_TOTAL-2:0], zero_in};
        end
    end

    aarm_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .aclk  (aclk),
        .ce    (ce),
        .angle (s_data.angle),
        .trig  (trig)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            trig_dly_reg[0] <= trig;
            for (int i = 1; i < CS_DELAY; i++) begin
                trig_dly_reg[i] <= trig_dly_reg[i-1];
            end
        end
    end

    aarm_norm u_norm (
        .aclk   (aclk),
        .ce     (ce),
        .axis_x (s_data.axis_x),
        .axis_y (s_data.axis_y),
        .axis_z (s_data.axis_z),
        .unit   (unit)
    );

    aarm_matrix u_matrix (
        .aclk   (aclk),
        .ce     (ce),
        .trig   (trig_dly_reg[CS_DELAY-1]),
        .unit   (unit),
        .zero   (zero_reg[LAT_TOTAL-2]),
        .result (m_data)
    );

    a_zero_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_axis |->
            m_data.m00 == Q14_ONE && m_data.m11 == Q14_ONE && m_data.m22 == Q14_ONE &&
            m_data.m01 == '0 && m_data.m02 == '0 && m_data.m10 == '0 &&
            m_data.m12 == '0 && m_data.m20 == '0 && m_data.m21 == '0)
        else $error("zero axis request did not give the identity");

    a_zero_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.zero_axis == zero_reg[LAT_TOTAL-1])
        else $error("zero flag out of step with the matrix");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request lost at pipeline entry");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule

### rtl/core/aarm_cordic.sv
// Angle to phase, quadrant fold and pipelined CORDIC giving cosine and sine in Q24.
`timescale 1ns / 1ps
module aarm_cordic import aarm_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [15:0] angle,
    output trig_t              trig
);

    logic signed [CW-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] z_reg [0:CORDIC_STAGES];
    logic                 flip_reg [0:CORDIC_STAGES];
    trig_t                trig_reg;

    logic signed [34:0]   phase_prod;
    logic [31:0]          phase;
    logic                 flip;
    logic [31:0]          folded;
    logic signed [CW-1:0] xf;
    logic signed [CW-1:0] yf;

    assign phase_prod = 35'(angle) * 35'(TURN_PER_RAD_Q20);
    assign phase      = phase_prod[31:0];
    assign flip       = phase[31] ^ phase[30];
    assign folded     = {phase[31] ^ flip, phase[30:0]};

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg[0]    <= CORDIC_GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= CW'(signed'(folded));
            flip_reg[0] <= flip;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [CW-1:0] AT = CW'(ATAN_TURNS[i]);
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (!z_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - AT;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + AT;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign xf = flip_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
    assign yf = flip_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];

    always_ff @(posedge aclk) begin
        if (ce) begin
            trig_reg.c <= QW'((xf + CW'(32)) >>> 6);
            trig_reg.s <= QW'((yf + CW'(32)) >>> 6);
        end
    end

    assign trig = trig_reg;

endmodule

### rtl/core/aarm_norm.sv
// Axis normalisation: squared length, pipelined square root and three rounded divider lanes.
`timescale 1ns / 1ps
module aarm_norm import aarm_pkg::*; (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    output unit_t              unit
);

    logic signed [15:0] comp [0:2];
    logic [15:0]        mag  [0:2];

    logic [31:0] sq_reg   [0:2];
    logic [15:0] mag0_reg [0:2];
    logic        sgn0_reg [0:2];
    logic [31:0] l_reg;
    logic [15:0] mag1_reg [0:2];
    logic        sgn1_reg [0:2];

    logic [31:0] lsq_reg  [0:SQRT_STEPS-1];
    logic [31:0] root_reg [0:SQRT_STEPS-1];
    logic [33:0] rem_reg  [0:SQRT_STEPS-1];
    logic [15:0] mags_reg [0:SQRT_STEPS-1][0:2];
    logic        sgns_reg [0:SQRT_STEPS-1][0:2];

    logic [31:0]    len_reg  [0:DIV_STEPS-1];
    logic [31:0]    drem_reg [0:DIV_STEPS-1][0:2];
    logic [QW-1:0]  q_reg    [0:DIV_STEPS-1][0:2];
    logic           sgnd_reg [0:DIV_STEPS-1][0:2];

    unit_t unit_reg;

    assign comp[0] = axis_x;
    assign comp[1] = axis_y;
    assign comp[2] = axis_z;

    for (genvar l = 0; l < 3; l++) begin : g_in
        assign mag[l] = comp[l][15] ? 16'(-comp[l]) : 16'(comp[l]);
        always_ff @(posedge aclk) begin
            if (ce) begin
                sq_reg[l]   <= 32'(mag[l]) * 32'(mag[l]);
                mag0_reg[l] <= mag[l];
                sgn0_reg[l] <= comp[l][15];
                mag1_reg[l] <= mag0_reg[l];
                sgn1_reg[l] <= sgn0_reg[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            l_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        logic [31:0] lsq_prev;
        logic [31:0] root_prev;
        logic [33:0] rem_prev;
        logic [1:0]  pair;
        logic [35:0] rem2;
        logic [35:0] trial;
        logic        ge;
        if (j == 0) begin : g_first
            assign lsq_prev  = l_reg;
            assign root_prev = '0;
            assign rem_prev  = '0;
        end else begin : g_next
            assign lsq_prev  = lsq_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
        end
        if (j < 16) begin : g_pair
            assign pair = lsq_prev[31-2*j -: 2];
        end else begin : g_nopair
            assign pair = 2'b00;
        end
        assign rem2  = {rem_prev, pair};
        assign trial = {2'b00, root_prev, 2'b01};
        assign ge    = (rem2 >= trial);
        always_ff @(posedge aclk) begin
            if (ce) begin
                lsq_reg[j]  <= lsq_prev;
                root_reg[j] <= {root_prev[30:0], ge};
                rem_reg[j]  <= ge ? 34'(rem2 - trial) : 34'(rem2);
            end
        end
        for (genvar l = 0; l < 3; l++) begin : g_carry
            always_ff @(posedge aclk) begin
                if (ce) begin
                    mags_reg[j][l] <= (j == 0) ? mag1_reg[l] : mags_reg[(j == 0) ? 0 : j-1][l];
                    sgns_reg[j][l] <= (j == 0) ? sgn1_reg[l] : sgns_reg[(j == 0) ? 0 : j-1][l];
                end
            end
        end
    end

    for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
        logic [31:0] len_prev;
        if (d == 0) begin : g_len0
            assign len_prev = root_reg[SQRT_STEPS-1];
        end else begin : g_lenn
            assign len_prev = len_reg[d-1];
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                len_reg[d] <= len_prev;
            end
        end
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [31:0]   rem_prev;
            logic [QW-1:0] q_prev;
            logic          sgn_prev;
            logic [32:0]   rem2;
            logic          ge;
            if (d == 0) begin : g_start
                assign rem_prev = 32'({mags_reg[SQRT_STEPS-1][l], 9'b0, len_prev[31:27]});
                assign q_prev   = '0;
                assign sgn_prev = sgns_reg[SQRT_STEPS-1][l];
            end else begin : g_cont
                assign rem_prev = drem_reg[d-1][l];
                assign q_prev   = q_reg[d-1][l];
                assign sgn_prev = sgnd_reg[d-1][l];
            end
            assign rem2 = {rem_prev, len_prev[DIV_STEPS-d]};
            assign ge   = (rem2 >= {1'b0, len_prev});
            always_ff @(posedge aclk) begin
                if (ce) begin
                    drem_reg[d][l] <= ge ? 32'(rem2 - {1'b0, len_prev}) : 32'(rem2);
                    q_reg[d][l]    <= {q_prev[QW-2:0], ge};
                    sgnd_reg[d][l] <= sgn_prev;
                end
            end
        end
    end

    function automatic logic signed [QW-1:0] signed_unit(input logic [QW-1:0] q,
                                                          input logic sgn);
        logic [QW-1:0] qc;
        qc = (q > ONE_Q24) ? ONE_Q24 : q;
        return sgn ? -signed'(qc) : signed'(qc);
    endfunction

    always_ff @(posedge aclk) begin
        if (ce) begin
            unit_reg.x <= signed_unit(q_reg[DIV_STEPS-1][0], sgnd_reg[DIV_STEPS-1][0]);
            unit_reg.y <= signed_unit(q_reg[DIV_STEPS-1][1], sgnd_reg[DIV_STEPS-1][1]);
            unit_reg.z <= signed_unit(q_reg[DIV_STEPS-1][2], sgnd_reg[DIV_STEPS-1][2]);
        end
    end

    assign unit = unit_reg;

endmodule

### rtl/core/aarm_matrix.sv
// Rodrigues matrix assembly: product stages, then a sum stage with Q1.14 rounding and saturation.
`timescale 1ns / 1ps
module aarm_matrix import aarm_pkg::*; (
    input  logic  aclk,
    input  logic  ce,
    input  trig_t trig,
    input  unit_t unit,
    input  logic  zero,
    output out_t  result
);

    logic signed [QW-1:0] n_in [0:2];
    logic signed [QW:0]   t;

    logic signed [52:0]   up_reg [0:2];
    logic signed [51:0]   sp_reg [0:2];
    logic signed [QW-1:0] na_reg [0:2];
    logic signed [QW-1:0] ca_reg;

    logic signed [QW:0]   u [0:2];
    logic signed [52:0]   pp_reg [0:5];
    logic signed [QW-1:0] sn_reg [0:2];
    logic signed [QW-1:0] cb_reg;

    logic signed [QW:0]   p [0:5];
    out_t                 result_reg;

    assign n_in[0] = unit.x;
    assign n_in[1] = unit.y;
    assign n_in[2] = unit.z;
    assign t = signed'({1'b0, ONE_Q24}) - (QW+1)'(trig.c);

    for (genvar l = 0; l < 3; l++) begin : g_a
        always_ff @(posedge aclk) begin
            if (ce) begin
                up_reg[l] <= 53'(n_in[l]) * 53'(t);
                sp_reg[l] <= 52'(n_in[l]) * 52'(trig.s);
                na_reg[l] <= n_in[l];
                sn_reg[l] <= QW'((sp_reg[l] + (52'sd1 <<< 23)) >>> 24);
            end
        end
        assign u[l] = (QW+1)'((up_reg[l] + (53'sd1 <<< 23)) >>> 24);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ca_reg    <= trig.c;
            cb_reg    <= ca_reg;
            pp_reg[0] <= 53'(u[0]) * 53'(na_reg[0]);
            pp_reg[1] <= 53'(u[1]) * 53'(na_reg[1]);
            pp_reg[2] <= 53'(u[2]) * 53'(na_reg[2]);
            pp_reg[3] <= 53'(u[0]) * 53'(na_reg[1]);
            pp_reg[4] <= 53'(u[0]) * 53'(na_reg[2]);
            pp_reg[5] <= 53'(u[1]) * 53'(na_reg[2]);
        end
    end

    for (genvar k = 0; k < 6; k++) begin : g_p
        assign p[k] = (QW+1)'((pp_reg[k] + (53'sd1 <<< 23)) >>> 24);
    end

    function automatic logic signed [15:0] to_q14(input logic signed [QW+2:0] v);
        logic signed [QW+3:0] r;
        r = (QW+4)'((QW+4)'(v) + (QW+4)'(512)) >>> 10;
        if (r > (QW+4)'(32767)) begin
            return 16'sh7FFF;
        end else if (r < -(QW+4)'(32768)) begin
            return 16'sh8000;
        end
        return 16'(r);
    endfunction

    function automatic logic signed [QW+2:0] sum3(input logic signed [QW:0] a,
                                                  input logic signed [QW-1:0] b,
                                                  input logic signed [QW-1:0] c,
                                                  input logic neg);
        logic signed [QW+2:0] e;
        e = (QW+3)'(a) + (QW+3)'(b);
        return neg ? e - (QW+3)'(c) : e + (QW+3)'(c);
    endfunction

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (zero) begin
                result_reg <= '{m00: Q14_ONE, m11: Q14_ONE, m22: Q14_ONE,
                                zero_axis: 1'b1, default: '0};
            end else begin
                result_reg.m00       <= to_q14(sum3(p[0], cb_reg, '0, 1'b0));
                result_reg.m11       <= to_q14(sum3(p[1], cb_reg, '0, 1'b0));
                result_reg.m22       <= to_q14(sum3(p[2], cb_reg, '0, 1'b0));
                result_reg.m01       <= to_q14(sum3(p[3], sn_reg[2], '0, 1'b0));
                result_reg.m10       <= to_q14(sum3(p[3], '0, sn_reg[2], 1'b1));
                result_reg.m02       <= to_q14(sum3(p[4], '0, sn_reg[1], 1'b1));
                result_reg.m20       <= to_q14(sum3(p[4], sn_reg[1], '0, 1'b0));
                result_reg.m12       <= to_q14(sum3(p[5], sn_reg[0], '0, 1'b0));
                result_reg.m21       <= to_q14(sum3(p[5], '0, sn_reg[0], 1'b1));
                result_reg.zero_axis <= 1'b0;
            end
        end
    end

    assign result = result_reg;

endmodule

### tb/axis_angle_rotation_matrix_top_tb.sv
// Testbench: axis-angle rotation matrix block checked against a bit-true predictor.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_top_tb;
    import aarm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    out_t matrix_q[$];
    int   errors = 0;
    int   cycles = 0;
    bit   src_idle_en = 1'b1;
    bit   sink_idle_en = 1'b1;
    bit   hold_req = 1'b0;

    axis_angle_rotation_matrix_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint rnd_sh(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic logic [15:0] to_q14(longint v);
        longint r;
        r = rnd_sh(v, 10);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic longint unit_of(longint v, longint unsigned len);
        longint unsigned mag, q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q = ((mag << 40) + (len >> 1)) / len;
        if (q > 64'd16777216) q = 64'd16777216;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic out_t predict_matrix(in_t r);
        out_t o;
        longint ang, ax, ay, az, x, y, z, dx, dy, c, s, t;
        longint nx, ny, nz, ux, uy, uz, pxx, pyy, pzz, pxy, pxz, pyz, sx, sy, sz;
        longint unsigned v, res, bv, len;
        logic [31:0] ph;
        bit flip;
        ang = r.angle; ax = r.axis_x; ay = r.axis_y; az = r.axis_z;
        o = '0;
        if (ax == 0 && ay == 0 && az == 0) begin
            o.m00 = Q14_ONE; o.m11 = Q14_ONE; o.m22 = Q14_ONE;
            o.zero_axis = 1'b1;
            return o;
        end
        ph = 32'(ang * 166886);
        flip = ph[31] ^ ph[30];
        if (flip) ph = ph + 32'h80000000;
        z = longint'($signed(ph));
        x = 64'h26DD3B6A;
        y = 0;
        for (int k = 0; k < CORDIC_STAGES_DEF && k < ATAN_ENTRIES; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURNS[k]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURNS[k]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = rnd_sh(x, 6);
        s = rnd_sh(y, 6);
        v = longint'(ax * ax + ay * ay + az * az) << 32;
        res = 0;
        bv = 64'd1 << 62;
        while (bv > v) bv >>= 2;
        while (bv != 0) begin
            if (v >= res + bv) begin
                v -= res + bv;
                res = (res >> 1) + bv;
            end else begin
                res >>= 1;
            end
            bv >>= 2;
        end
        len = res;
        nx = unit_of(ax, len); ny = unit_of(ay, len); nz = unit_of(az, len);
        t = (longint'(1) << 24) - c;
        ux = rnd_sh(nx * t, 24); uy = rnd_sh(ny * t, 24); uz = rnd_sh(nz * t, 24);
        pxx = rnd_sh(ux * nx, 24); pyy = rnd_sh(uy * ny, 24); pzz = rnd_sh(uz * nz, 24);
        pxy = rnd_sh(ux * ny, 24); pxz = rnd_sh(ux * nz, 24); pyz = rnd_sh(uy * nz, 24);
        sx = rnd_sh(nx * s, 24); sy = rnd_sh(ny * s, 24); sz = rnd_sh(nz * s, 24);
        o.m00 = to_q14(pxx + c); o.m01 = to_q14(pxy + sz); o.m02 = to_q14(pxz - sy);
        o.m10 = to_q14(pxy - sz); o.m11 = to_q14(pyy + c); o.m12 = to_q14(pyz + sx);
        o.m20 = to_q14(pxz + sy); o.m21 = to_q14(pyz - sx); o.m22 = to_q14(pzz + c);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
        errors++;
    endtask

    task automatic send_request(in_t item);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        matrix_q.push_back(predict_matrix(item));
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    function automatic in_t mk(int a, int x, int y, int z);
        in_t r;
        r.angle = a[15:0]; r.axis_x = x[15:0]; r.axis_y = y[15:0]; r.axis_z = z[15:0];
        return r;
    endfunction

    function automatic in_t rand_request();
        in_t r;
        int sel;
        r = in_t'({$urandom, $urandom});
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            r.axis_x = '0; r.axis_y = '0; r.axis_z = '0;
        end else if (sel < 5) begin
            r.axis_x = 16'($signed($urandom_range(0, 6)) - 3);
            r.axis_y = 16'($signed($urandom_range(0, 6)) - 3);
            r.axis_z = 16'($signed($urandom_range(0, 6)) - 3);
        end else if (sel < 8) begin
            r.axis_y = '0;
            if (sel == 7) r.axis_z = '0;
        end
        return r;
    endfunction

    // Receiver: random back-pressure, plus a long hold when asked.
    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (matrix_q.size() == 0) begin
                $display("unexpected matrix at cycle %0d", cycles);
                errors++;
            end else begin
                want = matrix_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (m_data[144 - 16 * k -: 16] !== want[144 - 16 * k -: 16])
                        report_mismatch($sformatf("m%0d%0d", k / 3, k % 3),
                                        m_data[144 - 16 * k -: 16], want[144 - 16 * k -: 16]);
                if (m_data.zero_axis !== want.zero_axis)
                    report_mismatch("zero_axis", 16'(m_data.zero_axis), 16'(want.zero_axis));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("axis_angle_rotation_matrix_top_tb NOT OK");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(mk(0, 0, 0, 0));
        send_request(mk(12345, 0, 0, 0));
        send_request(mk(-32768, 0, 0, 0));
        send_request(mk(0, 256, 0, 0));
        send_request(mk(6434, 0, 256, 0));
        send_request(mk(12868, 0, 0, 256));
        send_request(mk(-6434, 256, 256, 256));
        send_request(mk(32767, 32767, 32767, 32767));
        send_request(mk(-32768, -32768, -32768, -32768));
        send_request(mk(32767, -32768, 32767, -32768));
        send_request(mk(25736, 1, 0, 0));
        send_request(mk(-1, 0, -1, 0));
        send_request(mk(1, 0, 0, -1));
        send_request(mk(19302, 32767, 0, 0));
        send_request(mk(-19302, 0, -32768, 0));
        send_request(mk(3217, 1, 1, 1));
        send_request(mk(-32768, 32767, 1, -1));
        send_request(mk(9651, -256, 512, -768));
    endtask

    task automatic test_pressure();
        hold_req = 1'b1;
        repeat (100) send_request(rand_request());
    endtask

    task automatic test_random(int n);
        repeat (n) send_request(rand_request());
    endtask

    task automatic test_flat_out();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        repeat (100) send_request(rand_request());
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_pressure();
        test_random(480);
        test_flat_out();
        s_valid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge aclk);
        repeat (LAT_TOTAL + 10) @(posedge aclk);
        if (errors == 0)
            $display("axis_angle_rotation_matrix_top_tb OK");
        else
            $display("axis_angle_rotation_matrix_top_tb NOT OK");
        $finish;
    end
endmodule

### sim.f
rtl/core/aarm_pkg.sv
rtl/core/aarm_cordic.sv
rtl/core/aarm_norm.sv
rtl/core/aarm_matrix.sv
rtl/core/axis_angle_rotation_matrix_top.sv
tb/axis_angle_rotation_matrix_top_tb.sv
